### hw/rtl/vga_pkg.sv
// ----------------------------------------------------------------------------
// vga_pkg
// Shared types, request codes and helpers for the video gate array.
// ----------------------------------------------------------------------------
package vga_pkg;

   // Request codes on req_type.
   localparam logic [2:0] TYPE_PORT    = 3'd0;
   localparam logic [2:0] TYPE_VIDEO   = 3'd1;
   localparam logic [2:0] TYPE_TICK    = 3'd2;
   localparam logic [2:0] TYPE_IRQ_ACK = 3'd3;
   localparam logic [2:0] TYPE_APPLY   = 3'd4;
   localparam logic [2:0] TYPE_LINE    = 3'd5;
   localparam logic [2:0] TYPE_BORDER  = 3'd6;

   // Result kinds.
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_BORDER = 2'd2;

   // Gate array write functions, taken from data bits 7..6.
   localparam logic [1:0] WR_PEN    = 2'd0;
   localparam logic [1:0] WR_COLOUR = 2'd1;
   localparam logic [1:0] WR_MODE   = 2'd2;
   localparam logic [1:0] WR_BANK   = 2'd3;

   // Port decode.
   localparam logic [7:0] PORT_GA      = 8'h7F;
   localparam logic [7:0] PORT_ROM     = 8'hDF;
   localparam logic [4:0] PORT_BANK_HI = 5'b01111;

   // Screen modes.
   localparam logic [1:0] MODE_0 = 2'd0;
   localparam logic [1:0] MODE_1 = 2'd1;
   localparam logic [1:0] MODE_2 = 2'd2;
   localparam logic [1:0] MODE_3 = 2'd3;

   // Palette and line counter.
   localparam int         PAL_DEPTH  = 17;
   localparam int         PAL_AW     = 5;
   localparam logic [4:0] BORDER_PEN = 5'd16;
   localparam logic [6:0] LINE_WRAP  = 7'd51;

   // Register state that travels with every result.
   typedef struct packed {
      logic       lower_rom;
      logic       upper_rom;
      logic [5:0] ram_bank;
      logic [2:0] ram_layout;
      logic [7:0] rom_number;
      logic [5:0] line_count;
   } status_type;

   // Palette write request.
   typedef struct packed {
      logic              en;
      logic [PAL_AW-1:0] addr;
      logic [4:0]        colour;
   } pal_wr_type;

   // Metadata of a result whose colour is still being read.
   typedef struct packed {
      logic [1:0] kind;
      logic       last;
      logic       handled;
      logic       irq;
      status_type status;
   } meta_type;

   // Pen of pixel idx (0 is leftmost) of a video byte in the given mode.
   function automatic logic [3:0] pen_of(input logic [1:0] mode, input logic [7:0] b,
                                         input logic [2:0] idx);
      logic [1:0] grp;
      logic [3:0] pa;
      logic [3:0] pc;
      logic [3:0] pen;
      grp = idx[2:1];
      pa  = {b[1], b[5], b[3], b[7]};
      pc  = {b[0], b[4], b[2], b[6]};
      case (mode)
         MODE_2: pen = {3'b000, b[~idx]};
         MODE_1: pen = {2'b00, b[{1'b0, ~grp}], b[{1'b1, ~grp}]};
         MODE_3: pen = {2'b00, idx[2] ? pc[1:0] : pa[1:0]};
         default: pen = idx[2] ? pc : pa;
      endcase
      return pen;
   endfunction

endpackage

### hw/rtl/vga_palette.sv
// ----------------------------------------------------------------------------
// vga_palette
// Seventeen-entry colour palette (sixteen pens and the border) in a
// synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module vga_palette
   import vga_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  pal_wr_type        wr,
   input  logic              rd_en,
   input  logic [PAL_AW-1:0] rd_addr,
   output logic [4:0]        rd_data
);

   logic [4:0]           mem_ff [PAL_DEPTH];
   logic [PAL_DEPTH-1:0] valid_ff;
   logic [4:0]           rd_data_ff;

   // Colour storage; an entry is only trusted once written.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.colour;
      end
   end

   // Written flags, so that reset reads back as colour zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // Registered read; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : 5'd0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/vga_regs.sv
// ----------------------------------------------------------------------------
// vga_regs
// Control registers of the gate array: port write decode, pen select,
// screen modes, ROM enables, RAM banking and the interrupt line counter.
// ----------------------------------------------------------------------------
module vga_regs
   import vga_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [2:0] req_type,
   input  logic [7:0] port_high,
   input  logic [7:0] data,
   output status_type status_nxt,
   output logic       handled,
   output logic       irq,
   output pal_wr_type pal_wr,
   output logic [1:0] line_mode
);

   logic [4:0] sel_pen_ff,   sel_pen_in;
   logic [1:0] scr_mode_ff,  scr_mode_in;
   logic [1:0] pend_mode_ff, pend_mode_in;
   logic       pend_vld_ff,  pend_vld_in;
   logic [1:0] line_mode_ff, line_mode_in;
   status_type status_ff;
   logic [6:0] tick_sum;
   logic [1:0] wr_fn;
   logic       ga_port;
   logic       bank_port;

   assign wr_fn     = data[7:6];
   assign ga_port   = (port_high == PORT_GA) && (wr_fn != WR_BANK);
   assign bank_port = (port_high[7:3] == PORT_BANK_HI) && (wr_fn == WR_BANK);
   assign tick_sum  = {1'b0, status_ff.line_count} + 7'd1;

   // Next state for the item being taken.
   always_comb begin
      sel_pen_in   = sel_pen_ff;
      scr_mode_in  = scr_mode_ff;
      pend_mode_in = pend_mode_ff;
      pend_vld_in  = pend_vld_ff;
      line_mode_in = line_mode_ff;
      status_nxt   = status_ff;
      handled      = 1'b0;
      irq          = 1'b0;
      pal_wr.en     = 1'b0;
      pal_wr.addr   = (sel_pen_ff > BORDER_PEN) ? BORDER_PEN : sel_pen_ff;
      pal_wr.colour = data[4:0];
      case (req_type)
         TYPE_PORT: begin
            if (ga_port) begin
               handled = 1'b1;
               case (wr_fn)
                  WR_PEN: begin
                     sel_pen_in = data[4] ? BORDER_PEN : {1'b0, data[3:0]};
                  end
                  WR_COLOUR: begin
                     pal_wr.en = 1'b1;
                  end
                  default: begin
                     pend_mode_in         = data[1:0];
                     pend_vld_in          = 1'b1;
                     status_nxt.lower_rom = ~data[2];
                     status_nxt.upper_rom = ~data[3];
                     if (data[4]) begin
                        status_nxt.line_count = 6'd0;
                        irq                   = 1'b1;
                     end
                  end
               endcase
            end else if (bank_port) begin
               handled               = 1'b1;
               status_nxt.ram_bank   = {~port_high[2:0], data[5:3]};
               status_nxt.ram_layout = data[2:0];
            end else if (port_high == PORT_ROM) begin
               handled               = 1'b1;
               status_nxt.rom_number = data;
            end
         end
         TYPE_TICK: begin
            if (tick_sum > LINE_WRAP) begin
               status_nxt.line_count = 6'd0;
               irq                   = 1'b1;
            end else begin
               status_nxt.line_count = tick_sum[5:0];
            end
         end
         TYPE_IRQ_ACK: begin
            status_nxt.line_count = {1'b0, status_ff.line_count[4:0]};
         end
         TYPE_APPLY: begin
            if (pend_vld_ff) begin
               scr_mode_in = pend_mode_ff;
               pend_vld_in = 1'b0;
            end
         end
         TYPE_LINE: begin
            line_mode_in = scr_mode_ff;
         end
         default: begin
         end
      endcase
      pal_wr.en = pal_wr.en & take;
   end

   // State update on each taken item.
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_pen_ff           <= 5'd0;
         scr_mode_ff          <= MODE_1;
         pend_mode_ff         <= MODE_0;
         pend_vld_ff          <= 1'b0;
         line_mode_ff         <= MODE_1;
         status_ff.lower_rom  <= 1'b1;
         status_ff.upper_rom  <= 1'b1;
         status_ff.ram_bank   <= 6'd0;
         status_ff.ram_layout <= 3'd0;
         status_ff.rom_number <= 8'd0;
         status_ff.line_count <= 6'd0;
      end else if (take) begin
         sel_pen_ff   <= sel_pen_in;
         scr_mode_ff  <= scr_mode_in;
         pend_mode_ff <= pend_mode_in;
         pend_vld_ff  <= pend_vld_in;
         line_mode_ff <= line_mode_in;
         status_ff    <= status_nxt;
      end
   end

   assign line_mode = line_mode_ff;

endmodule

### hw/rtl/video_gate_array_top.sv
// ----------------------------------------------------------------------------
// video_gate_array_top
// Gate array: register decode, pixel decode of fetched video bytes and
// palette lookup, with one result per cycle on the response channel while it is ready.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   req       in          req_valid/req_ready    req_type, req_port_high, req_data
//   rsp       out         rsp_valid/rsp_ready    kind, colour, last, status fields
//
// Register items may follow back to back while the response channel is ready.
// The eight pixels of a video byte share the single palette read port, one
// lookup per cycle while the output does not stall; no new request is taken
// until the last pixel is issued. Results pass the palette read stage, then
// the output register. A stalled response holds the pipeline; no transfer is lost.
// Reset is synchronous; the palette reads as zero until each pen is written.
// ----------------------------------------------------------------------------
module video_gate_array_top
   import vga_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_type,
   input  logic [7:0] req_port_high,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [4:0] rsp_pixel_colour,
   output logic       rsp_last,
   output logic       rsp_handled,
   output logic       rsp_irq_request,
   output logic       rsp_lower_rom_enable,
   output logic       rsp_upper_rom_enable,
   output logic [5:0] rsp_ram_bank,
   output logic [2:0] rsp_ram_layout,
   output logic [7:0] rsp_upper_rom_number,
   output logic [5:0] rsp_line_count
);

   logic              take;
   logic              slot_free;
   logic              issue;
   logic              s1_adv;
   status_type        status_nxt;
   logic              handled;
   logic              irq;
   pal_wr_type        pal_wr;
   logic [1:0]        line_mode;
   logic [PAL_AW-1:0] rd_addr;
   logic [4:0]        rd_data;
   meta_type          issue_meta;

   logic              burst_ff,  burst_in;
   logic [2:0]        beat_ff,   beat_in;
   logic [7:0]        vbyte_ff;
   logic [1:0]        vmode_ff;
   status_type        vstat_ff;
   logic              s1_vld_ff, s1_vld_in;
   meta_type          s1_ff;
   logic              out_vld_ff, out_vld_in;
   meta_type          out_ff;
   logic [4:0]        out_col_ff;

   // Pipeline flow: a slot opens when the read stage is empty or moving on.
   assign s1_adv    = s1_vld_ff && (!out_vld_ff || rsp_ready);
   assign slot_free = !s1_vld_ff || s1_adv;
   assign req_ready = slot_free && !burst_ff;
   assign take      = req_valid && req_ready;
   assign issue     = take || (burst_ff && slot_free);

   vga_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .req_type   (req_type),
      .port_high  (req_port_high),
      .data       (req_data),
      .status_nxt (status_nxt),
      .handled    (handled),
      .irq        (irq),
      .pal_wr     (pal_wr),
      .line_mode  (line_mode)
   );

   // Read address and result metadata of the beat being issued.
   always_comb begin
      issue_meta.kind    = KIND_STATUS;
      issue_meta.last    = 1'b1;
      issue_meta.handled = 1'b0;
      issue_meta.irq     = 1'b0;
      issue_meta.status  = status_nxt;
      rd_addr            = BORDER_PEN;
      if (burst_ff) begin
         issue_meta.kind   = KIND_PIXEL;
         issue_meta.last   = (beat_ff == 3'd7);
         issue_meta.status = vstat_ff;
         rd_addr           = {1'b0, pen_of(vmode_ff, vbyte_ff, beat_ff)};
      end else begin
         case (req_type)
            TYPE_VIDEO: begin
               issue_meta.kind = KIND_PIXEL;
               issue_meta.last = 1'b0;
               rd_addr         = {1'b0, pen_of(line_mode, req_data, 3'd0)};
            end
            TYPE_BORDER: begin
               issue_meta.kind = KIND_BORDER;
            end
            TYPE_PORT: begin
               issue_meta.handled = handled;
               issue_meta.irq     = irq;
            end
            default: begin
               issue_meta.irq = irq;
            end
         endcase
      end
   end

   vga_palette u_palette (
      .clock   (clock),
      .reset   (reset),
      .wr      (pal_wr),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Pixel burst sequencer: beats one to seven of a video byte.
   always_comb begin
      burst_in = burst_ff;
      beat_in  = beat_ff;
      if (burst_ff) begin
         if (slot_free) begin
            beat_in = beat_ff + 3'd1;
            if (beat_ff == 3'd7) begin
               burst_in = 1'b0;
            end
         end
      end else if (take && (req_type == TYPE_VIDEO)) begin
         burst_in = 1'b1;
         beat_in  = 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff <= 1'b0;
         beat_ff  <= 3'd0;
      end else begin
         burst_ff <= burst_in;
         beat_ff  <= beat_in;
      end
   end

   // The byte, its line mode and the status snapshot held for the burst.
   always_ff @(posedge clock) begin
      if (take) begin
         vbyte_ff <= req_data;
         vmode_ff <= line_mode;
         vstat_ff <= status_nxt;
      end
   end

   // Read stage: metadata beside the palette read in flight.
   assign s1_vld_in = issue ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_ff <= issue_meta;
      end
   end

   // Output register toward the response channel.
   assign out_vld_in = s1_adv ? 1'b1 : ((out_vld_ff && !rsp_ready) ? 1'b1 : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_ff     <= s1_ff;
         out_col_ff <= (s1_ff.kind == KIND_STATUS) ? 5'd0 : rd_data;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_result_kind      = out_ff.kind;
   assign rsp_pixel_colour     = out_col_ff;
   assign rsp_last             = out_ff.last;
   assign rsp_handled          = out_ff.handled;
   assign rsp_irq_request      = out_ff.irq;
   assign rsp_lower_rom_enable = out_ff.status.lower_rom;
   assign rsp_upper_rom_enable = out_ff.status.upper_rom;
   assign rsp_ram_bank         = out_ff.status.ram_bank;
   assign rsp_ram_layout       = out_ff.status.ram_layout;
   assign rsp_upper_rom_number = out_ff.status.rom_number;
   assign rsp_line_count       = out_ff.status.line_count;

endmodule

### tb/gate_array_score_pkg.sv
// ----------------------------------------------------------------------------
// gate_array_score_pkg
// Result prediction and result checking for the video gate array bench.
// ----------------------------------------------------------------------------
package gate_array_score_pkg;
   import vga_pkg::*;

   // The one request code that the block leaves unused.
   localparam logic [2:0] TYPE_UNUSED = 3'd7;

   // One result as it leaves the response channel.
   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] colour;
      logic       last;
      logic       handled;
      logic       irq;
      logic       lower_rom;
      logic       upper_rom;
      logic [5:0] ram_bank;
      logic [2:0] ram_layout;
      logic [7:0] rom_number;
      logic [5:0] line_count;
   } gate_result_type;

   class gate_array_tracker;
      // Predicted copy of the block's state.
      logic [4:0]   palette [PAL_DEPTH];
      logic [4:0]   sel_pen;
      logic [1:0]   disp_mode;
      logic [1:0]   pend_mode;
      logic         pend_valid;
      logic [1:0]   line_mode;
      logic [5:0]   line_ctr;
      logic         lower_on;
      logic         upper_on;
      logic [5:0]   bank_sel;
      logic [2:0]   layout_sel;
      logic [7:0]   rom_sel;

      gate_result_type expected_results [$];
      int              failures;

      function new();
         foreach (palette[i]) palette[i] = '0;
         sel_pen     = '0;
         disp_mode   = MODE_1;
         pend_mode   = MODE_0;
         pend_valid  = 1'b0;
         line_mode   = MODE_1;
         line_ctr    = '0;
         lower_on    = 1'b1;
         upper_on    = 1'b1;
         bank_sel    = '0;
         layout_sel  = '0;
         rom_sel     = '0;
         failures    = 0;
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction

      // Pen shown at pixel idx (0 is leftmost) of a video byte.
      function logic [3:0] pixel_pen(logic [1:0] mode, logic [7:0] b, int idx);
         logic [3:0] left_pen;
         logic [3:0] right_pen;
         logic [3:0] pen;
         left_pen  = {b[1], b[5], b[3], b[7]};
         right_pen = {b[0], b[4], b[2], b[6]};
         case (mode)
            MODE_2: pen = {3'b000, b[7 - idx]};
            MODE_1: pen = {2'b00, b[3 - idx / 2], b[7 - idx / 2]};
            default: begin
               pen = (idx < 4) ? left_pen : right_pen;
               if (mode == MODE_3) pen[3:2] = 2'b00;
            end
         endcase
         return pen;
      endfunction

      // Stamps the current register state into a result and queues it.
      function void queue_result(gate_result_type r);
         r.lower_rom  = lower_on;
         r.upper_rom  = upper_on;
         r.ram_bank   = bank_sel;
         r.ram_layout = layout_sel;
         r.rom_number = rom_sel;
         r.line_count = line_ctr;
         expected_results.push_back(r);
      endfunction

      // Applies one accepted request and queues the results it causes.
      function void note_request(logic [2:0] op, logic [7:0] port, logic [7:0] data);
         gate_result_type r;
         logic [1:0]      fn;
         logic [6:0]      next_line;
         r      = '0;
         r.last = 1'b1;
         fn     = data[7:6];
         case (op)
            TYPE_PORT: begin
               if (fn != WR_BANK && port == PORT_GA) begin
                  r.handled = 1'b1;
                  case (fn)
                     WR_PEN: sel_pen = data[4] ? BORDER_PEN : {1'b0, data[3:0]};
                     WR_COLOUR: palette[sel_pen] = data[4:0];
                     default: begin
                        pend_mode  = data[1:0];
                        pend_valid = 1'b1;
                        lower_on   = !data[2];
                        upper_on   = !data[3];
                        if (data[4]) begin
                           line_ctr = '0;
                           r.irq    = 1'b1;
                        end
                     end
                  endcase
               end else if (fn == WR_BANK && port[7:3] == PORT_BANK_HI) begin
                  r.handled  = 1'b1;
                  bank_sel   = {~port[2:0], data[5:3]};
                  layout_sel = data[2:0];
               end else if (port == PORT_ROM) begin
                  r.handled = 1'b1;
                  rom_sel   = data;
               end
               queue_result(r);
            end
            TYPE_VIDEO: begin
               // Eight pixels, leftmost first, through the palette.
               for (int i = 0; i < 8; i++) begin
                  r        = '0;
                  r.kind   = KIND_PIXEL;
                  r.colour = palette[pixel_pen(line_mode, data, i)];
                  r.last   = (i == 7);
                  queue_result(r);
               end
            end
            TYPE_TICK: begin
               next_line = {1'b0, line_ctr} + 7'd1;
               if (next_line > LINE_WRAP) begin
                  next_line = '0;
                  r.irq     = 1'b1;
               end
               line_ctr = next_line[5:0];
               queue_result(r);
            end
            TYPE_IRQ_ACK: begin
               line_ctr[5] = 1'b0;
               queue_result(r);
            end
            TYPE_APPLY: begin
               if (pend_valid) begin
                  disp_mode  = pend_mode;
                  pend_valid = 1'b0;
               end
               queue_result(r);
            end
            TYPE_LINE: begin
               line_mode = disp_mode;
               queue_result(r);
            end
            TYPE_BORDER: begin
               r.kind   = KIND_BORDER;
               r.colour = palette[BORDER_PEN];
               queue_result(r);
            end
            default: queue_result(r);
         endcase
      endfunction

      function void check_field(string field, int unsigned exp, int unsigned act);
         if (exp != act) begin
            $error("%s: expected %0d, actual %0d", field, exp, act);
            failures++;
         end
      endfunction

      // Compares a received result with the oldest prediction.
      function void check_result(gate_result_type got);
         gate_result_type exp;
         if (expected_results.size() == 0) begin
            $error("result received with no expected result waiting");
            failures++;
            return;
         end
         exp = expected_results.pop_front();
         check_field("result_kind", exp.kind, got.kind);
         check_field("pixel_colour", exp.colour, got.colour);
         check_field("last", exp.last, got.last);
         check_field("handled", exp.handled, got.handled);
         check_field("irq_request", exp.irq, got.irq);
         check_field("lower_rom_enable", exp.lower_rom, got.lower_rom);
         check_field("upper_rom_enable", exp.upper_rom, got.upper_rom);
         check_field("ram_bank", exp.ram_bank, got.ram_bank);
         check_field("ram_layout", exp.ram_layout, got.ram_layout);
         check_field("upper_rom_number", exp.rom_number, got.rom_number);
         check_field("line_count", exp.line_count, got.line_count);
      endfunction
   endclass

endpackage

### tb/video_gate_array_top_test.sv
// ----------------------------------------------------------------------------
// video_gate_array_top_test
// Drives port writes, video bytes and line events into the gate array with
// random gaps on both channels, predicts every result and checks each one.
// ----------------------------------------------------------------------------
module video_gate_array_top_test;
   import vga_pkg::*;
   import gate_array_score_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 292;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_type = TYPE_TICK;
   logic [7:0] req_port_high = '0;
   logic [7:0] req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [4:0] rsp_pixel_colour;
   logic       rsp_last;
   logic       rsp_handled;
   logic       rsp_irq_request;
   logic       rsp_lower_rom_enable;
   logic       rsp_upper_rom_enable;
   logic [5:0] rsp_ram_bank;
   logic [2:0] rsp_ram_layout;
   logic [7:0] rsp_upper_rom_number;
   logic [5:0] rsp_line_count;

   gate_array_tracker board;
   int  sent = 0;
   bit  calm = 1'b0;
   bit  hold_now = 1'b0;

   video_gate_array_top uut (.*);

   always #5 clock = ~clock;

   // Gap before a transfer: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one request and returns at the falling edge after its transfer.
   task automatic send_item(input logic [2:0] op, input logic [7:0] port,
                            input logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= op;
      req_port_high <= port;
      req_data      <= data;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, port, data);
      sent++;
      @(negedge clock);
   endtask

   // Stops offering until every predicted result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // Response side: random stalls, plus one long hold when asked for.
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_now) begin
            hold_now   = 1'b0;
            stall_left = 250;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (calm || $urandom_range(0, 99) < 65) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready  <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
         end
      end
   end

   // Every result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result({rsp_result_kind, rsp_pixel_colour, rsp_last, rsp_handled,
                             rsp_irq_request, rsp_lower_rom_enable, rsp_upper_rom_enable,
                             rsp_ram_bank, rsp_ram_layout, rsp_upper_rom_number,
                             rsp_line_count});
      end
   end

   initial begin : stimulus
      int  scenario;
      int  count;
      int  target;
      bit  held;
      bit  drained;
      held    = 1'b0;
      drained = 1'b0;
      board   = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: reset state, palette extremes, every mode and port decode.
      send_item(TYPE_TICK, 8'h00, 8'h00);
      send_item(TYPE_UNUSED, 8'hFF, 8'hFF);
      send_item(TYPE_VIDEO, 8'h00, 8'hFF);
      send_item(TYPE_PORT, PORT_GA, {WR_PEN, 6'h10});
      send_item(TYPE_PORT, PORT_GA, {WR_COLOUR, 6'h3F});
      send_item(TYPE_BORDER, 8'h00, 8'h00);
      send_item(TYPE_PORT, PORT_GA, {WR_PEN, 6'h0F});
      send_item(TYPE_PORT, PORT_GA, {WR_COLOUR, 6'h0A});
      send_item(TYPE_VIDEO, 8'hFF, 8'h88);
      // Mode 2 with both ROMs off and the line counter cleared.
      send_item(TYPE_PORT, PORT_GA, {WR_MODE, 6'h1E});
      send_item(TYPE_APPLY, 8'h00, 8'h00);
      send_item(TYPE_LINE, 8'h00, 8'h00);
      send_item(TYPE_VIDEO, 8'h00, 8'hA5);
      // Mode 0, then an apply with nothing pending.
      send_item(TYPE_PORT, PORT_GA, {WR_MODE, 6'h00});
      send_item(TYPE_APPLY, 8'h00, 8'h00);
      send_item(TYPE_APPLY, 8'h00, 8'h00);
      send_item(TYPE_LINE, 8'h00, 8'h00);
      send_item(TYPE_VIDEO, 8'h00, 8'h5A);
      // Mode 3 keeps only the low two bits of each pen.
      send_item(TYPE_PORT, PORT_GA, {WR_MODE, 6'h03});
      send_item(TYPE_APPLY, 8'h00, 8'h00);
      send_item(TYPE_LINE, 8'h00, 8'h00);
      send_item(TYPE_VIDEO, 8'h00, 8'hFF);
      // Banking at both ends of the port range, one just outside, ROM select.
      send_item(TYPE_PORT, 8'h78, 8'hFF);
      send_item(TYPE_PORT, PORT_GA, {WR_BANK, 6'h00});
      send_item(TYPE_PORT, 8'h77, 8'hC7);
      send_item(TYPE_PORT, PORT_ROM, 8'hFF);
      send_item(TYPE_PORT, PORT_ROM, 8'h00);
      send_item(TYPE_IRQ_ACK, 8'h00, 8'h00);

      // Random part, mostly well-formed sequences with random content.
      target = sent + RANDOM_ITEMS;
      while (sent < target) begin
         if (!held && sent >= target - 200) begin
            hold_now = 1'b1;
            held     = 1'b1;
         end
         if (!drained && sent >= target - 100) begin
            wait_for_drain();
            drained = 1'b1;
         end
         calm     = (sent >= target - 160 && sent < target - 120);
         scenario = $urandom_range(0, 99);
         if (scenario < 25) begin
            // Pick a pen, then give it a colour.
            send_item(TYPE_PORT, PORT_GA, {WR_PEN, 6'($urandom_range(0, 63))});
            send_item(TYPE_PORT, PORT_GA, {WR_COLOUR, 6'($urandom_range(0, 63))});
         end else if (scenario < 40) begin
            // New mode taken up at the next line, then a few video bytes.
            send_item(TYPE_PORT, PORT_GA, {WR_MODE, 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 3) == 0), 4'($urandom_range(0, 15))});
            send_item(TYPE_APPLY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            send_item(TYPE_LINE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            count = $urandom_range(1, 4);
            repeat (count) send_item(TYPE_VIDEO, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)));
         end else if (scenario < 55) begin
            count = $urandom_range(1, 4);
            repeat (count) send_item(TYPE_VIDEO, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)));
            send_item(TYPE_BORDER, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else if (scenario < 67) begin
            // Line ticks; a long run always passes the wrap point.
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(52, 60)
                                                : $urandom_range(1, 8);
            repeat (count) send_item(TYPE_TICK, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)));
            if ($urandom_range(0, 2) == 0)
               send_item(TYPE_IRQ_ACK, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
         end else if (scenario < 77) begin
            send_item(TYPE_PORT, {5'b01111, 3'($urandom_range(0, 7))},
                      {WR_BANK, 6'($urandom_range(0, 63))});
            send_item(TYPE_PORT, PORT_ROM, 8'($urandom_range(0, 255)));
         end else if (scenario < 85) begin
            send_item(3'($urandom_range(TYPE_IRQ_ACK, TYPE_LINE)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else begin
            // Noise: any request code, port and data.
            send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // Wait for the last results, then idle so that any stray result would be seen.
      while (board.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #10000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
